// ----- hw/rtl/mtcw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcw_pkg
// Types and constants shared by the markup text cell writer.
// ----------------------------------------------------------------------------
package mtcw_pkg;

   // markup and control characters
   localparam logic [6:0] CHAR_NUL         = 7'h00;
   localparam logic [6:0] CHAR_LF          = 7'h0A;
   localparam logic [6:0] CHAR_CR          = 7'h0D;
   localparam logic [6:0] CHAR_SPECIAL_ON  = 7'h5B;
   localparam logic [6:0] CHAR_SPECIAL_OFF = 7'h5D;
   localparam logic [6:0] CHAR_HILITE_ON   = 7'h7B;
   localparam logic [6:0] CHAR_UNDERLINE   = 7'h7C;
   localparam logic [6:0] CHAR_HILITE_OFF  = 7'h7D;

   // register indexes
   localparam logic [2:0] REG_GRID_COLUMNS   = 3'd0;
   localparam logic [2:0] REG_GRID_ROWS      = 3'd1;
   localparam logic [2:0] REG_NORMAL_TEXT    = 3'd2;
   localparam logic [2:0] REG_SPECIAL_TEXT   = 3'd3;
   localparam logic [2:0] REG_NORMAL_BACK    = 3'd4;
   localparam logic [2:0] REG_HIGHLIGHT_BACK = 3'd5;

   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [7:0] GRID_COLUMNS_RESET = 8'd40;
   localparam logic [7:0] GRID_ROWS_RESET    = 8'd30;

   typedef struct packed {
      logic [7:0]  grid_columns;
      logic [7:0]  grid_rows;
      logic [15:0] normal_text_color;
      logic [15:0] special_text_color;
      logic [15:0] normal_back_color;
      logic [15:0] highlight_back_color;
   } cfg_type;

   typedef struct packed {
      logic [6:0] char_code;
      logic       string_start;
      logic [7:0] start_column;
      logic [7:0] start_row;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  cell_column;
      logic [7:0]  cell_row;
      logic [7:0]  glyph_code;
      logic [15:0] fore_color;
      logic [15:0] back_color;
   } rsp_item_type;

endpackage

// ----- hw/rtl/mtcw_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcw_req_if
// Character request channel: valid/ready handshake with one character.
// ----------------------------------------------------------------------------
interface mtcw_req_if;
   logic       valid;
   logic       ready;
   logic [6:0] char_code;
   logic       string_start;
   logic [7:0] start_column;
   logic [7:0] start_row;

   modport source (
      output valid, char_code, string_start, start_column, start_row,
      input  ready
   );

   modport sink (
      input  valid, char_code, string_start, start_column, start_row,
      output ready
   );
endinterface

// ----- hw/rtl/mtcw_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcw_rsp_if
// Cell write channel: valid/ready handshake with one text cell.
// ----------------------------------------------------------------------------
interface mtcw_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  cell_column;
   logic [7:0]  cell_row;
   logic [7:0]  glyph_code;
   logic [15:0] fore_color;
   logic [15:0] back_color;

   modport source (
      output valid, cell_column, cell_row, glyph_code, fore_color, back_color,
      input  ready
   );

   modport sink (
      input  valid, cell_column, cell_row, glyph_code, fore_color, back_color,
      output ready
   );
endinterface

// ----- hw/rtl/markup_text_cell_writer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// markup_text_cell_writer
// Path: an accepted request is held in the input register, decoded, and its
//   cell write is loaded into the result register; markup, line breaks and
//   ignored characters produce nothing.
// Throughput: one request per cycle while the cell write channel does not stall.
// Reset: synchronous; the cursor and flags clear, the writer waits for a
//   string start, and the registers return to 40 columns, 30 rows, colors 0.
// ----------------------------------------------------------------------------
module markup_text_cell_writer (
   input  logic                                 clock,
   input  logic                                 reset,
   mtcw_req_if.sink                             req_chan,
   mtcw_rsp_if.source                           rsp_chan,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [mtcw_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [mtcw_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [mtcw_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready
);

   mtcw_pkg::cfg_type      cfg;
   mtcw_pkg::rsp_item_type result;
   logic                   result_valid;
   logic                   out_ready;

   mtcw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mtcw_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .cfg          (cfg),
      .out_ready    (out_ready),
      .result_valid (result_valid),
      .result       (result)
   );

   mtcw_rsp_stage u_rsp_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (result_valid),
      .item     (result),
      .can_take (out_ready),
      .rsp_chan (rsp_chan)
   );

endmodule

// ----- hw/rtl/mtcw_csr.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcw_csr
// APB-style register file holding grid size and the four colors.
// ----------------------------------------------------------------------------
module mtcw_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [mtcw_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [mtcw_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [mtcw_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready,
   output mtcw_pkg::cfg_type                    cfg
);

   mtcw_pkg::cfg_type cfg_ff;
   mtcw_pkg::cfg_type cfg_in;
   logic [2:0]        reg_index;
   logic              wr_en;

   assign reg_index  = csr_paddr[4:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            mtcw_pkg::REG_GRID_COLUMNS:   cfg_in.grid_columns         = csr_pwdata[7:0];
            mtcw_pkg::REG_GRID_ROWS:      cfg_in.grid_rows            = csr_pwdata[7:0];
            mtcw_pkg::REG_NORMAL_TEXT:    cfg_in.normal_text_color    = csr_pwdata[15:0];
            mtcw_pkg::REG_SPECIAL_TEXT:   cfg_in.special_text_color   = csr_pwdata[15:0];
            mtcw_pkg::REG_NORMAL_BACK:    cfg_in.normal_back_color    = csr_pwdata[15:0];
            mtcw_pkg::REG_HIGHLIGHT_BACK: cfg_in.highlight_back_color = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_columns         <= mtcw_pkg::GRID_COLUMNS_RESET;
         cfg_ff.grid_rows            <= mtcw_pkg::GRID_ROWS_RESET;
         cfg_ff.normal_text_color    <= 16'h0000;
         cfg_ff.special_text_color   <= 16'h0000;
         cfg_ff.normal_back_color    <= 16'h0000;
         cfg_ff.highlight_back_color <= 16'h0000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_index)
         mtcw_pkg::REG_GRID_COLUMNS:   csr_prdata = {24'h0, cfg_ff.grid_columns};
         mtcw_pkg::REG_GRID_ROWS:      csr_prdata = {24'h0, cfg_ff.grid_rows};
         mtcw_pkg::REG_NORMAL_TEXT:    csr_prdata = {16'h0, cfg_ff.normal_text_color};
         mtcw_pkg::REG_SPECIAL_TEXT:   csr_prdata = {16'h0, cfg_ff.special_text_color};
         mtcw_pkg::REG_NORMAL_BACK:    csr_prdata = {16'h0, cfg_ff.normal_back_color};
         mtcw_pkg::REG_HIGHLIGHT_BACK: csr_prdata = {16'h0, cfg_ff.highlight_back_color};
         default:                      csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/mtcw_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcw_engine
// Input register, cursor and markup flags, and the per-character decode.
// ----------------------------------------------------------------------------
module mtcw_engine (
   input  logic                   clock,
   input  logic                   reset,
   mtcw_req_if.sink               req_chan,
   input  mtcw_pkg::cfg_type      cfg,
   input  logic                   out_ready,
   output logic                   result_valid,
   output mtcw_pkg::rsp_item_type result
);

   logic                   in_valid_ff, in_valid_in;
   mtcw_pkg::req_item_type in_item_ff;

   logic [7:0] col_ff, col_in;
   logic [7:0] row_ff, row_in;
   logic       special_ff, special_in;
   logic       hilite_ff, hilite_in;
   logic       underline_ff, underline_in;
   logic       ended_ff, ended_in;

   logic       advance;
   logic       req_take;
   logic       emit;

   // working copies after the string start load
   logic [7:0] col_w, row_w;
   logic       special_w, hilite_w, underline_w, ended_w;

   assign advance        = in_valid_ff & out_ready;
   assign req_chan.ready = ~in_valid_ff | out_ready;
   assign req_take       = req_chan.valid & req_chan.ready;
   assign in_valid_in    = req_take | (in_valid_ff & ~advance);

   always_comb begin
      if (in_item_ff.string_start) begin
         col_w       = in_item_ff.start_column;
         row_w       = in_item_ff.start_row;
         special_w   = 1'b0;
         hilite_w    = 1'b0;
         underline_w = 1'b0;
         ended_w     = 1'b0;
      end else begin
         col_w       = col_ff;
         row_w       = row_ff;
         special_w   = special_ff;
         hilite_w    = hilite_ff;
         underline_w = underline_ff;
         ended_w     = ended_ff;
      end

      col_in       = col_w;
      row_in       = row_w;
      special_in   = special_w;
      hilite_in    = hilite_w;
      underline_in = underline_w;
      ended_in     = ended_w;
      emit         = 1'b0;

      if (!ended_w) begin
         if (in_item_ff.char_code == mtcw_pkg::CHAR_NUL
             || col_w >= cfg.grid_columns || row_w >= cfg.grid_rows) begin
            ended_in = 1'b1;
         end else begin
            case (in_item_ff.char_code)
               mtcw_pkg::CHAR_CR, mtcw_pkg::CHAR_LF: begin
                  row_in = row_w + 8'd1;
               end
               mtcw_pkg::CHAR_SPECIAL_ON:  special_in   = 1'b1;
               mtcw_pkg::CHAR_SPECIAL_OFF: special_in   = 1'b0;
               mtcw_pkg::CHAR_HILITE_ON:   hilite_in    = 1'b1;
               mtcw_pkg::CHAR_HILITE_OFF:  hilite_in    = 1'b0;
               mtcw_pkg::CHAR_UNDERLINE:   underline_in = ~underline_w;
               default: begin
                  emit   = 1'b1;
                  col_in = col_w + 8'd1;
               end
            endcase
         end
      end
   end

   assign result_valid       = advance & emit;
   assign result.cell_column = col_w;
   assign result.cell_row    = row_w;
   assign result.glyph_code  = {underline_w, in_item_ff.char_code};
   assign result.fore_color  = special_w ? cfg.special_text_color : cfg.normal_text_color;
   assign result.back_color  = hilite_w ? cfg.highlight_back_color : cfg.normal_back_color;

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.char_code    <= req_chan.char_code;
         in_item_ff.string_start <= req_chan.string_start;
         in_item_ff.start_column <= req_chan.start_column;
         in_item_ff.start_row    <= req_chan.start_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         col_ff       <= 8'd0;
         row_ff       <= 8'd0;
         special_ff   <= 1'b0;
         hilite_ff    <= 1'b0;
         underline_ff <= 1'b0;
         ended_ff     <= 1'b1;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            col_ff       <= col_in;
            row_ff       <= row_in;
            special_ff   <= special_in;
            hilite_ff    <= hilite_in;
            underline_ff <= underline_in;
            ended_ff     <= ended_in;
         end
      end
   end

endmodule

// ----- hw/rtl/mtcw_rsp_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcw_rsp_stage
// Result register driving the cell write channel.
// ----------------------------------------------------------------------------
module mtcw_rsp_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  mtcw_pkg::rsp_item_type item,
   output logic                   can_take,
   mtcw_rsp_if.source             rsp_chan
);

   logic                   out_valid_ff, out_valid_in;
   mtcw_pkg::rsp_item_type out_item_ff;

   assign can_take = ~out_valid_ff | rsp_chan.ready;

   // load only arrives while can_take is high
   assign out_valid_in = load | (out_valid_ff & ~rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_item_ff <= item;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.cell_column = out_item_ff.cell_column;
   assign rsp_chan.cell_row    = out_item_ff.cell_row;
   assign rsp_chan.glyph_code  = out_item_ff.glyph_code;
   assign rsp_chan.fore_color  = out_item_ff.fore_color;
   assign rsp_chan.back_color  = out_item_ff.back_color;

endmodule

// ----- dv/tb_markup_text_cell_writer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_markup_text_cell_writer
// Self-checking bench for the markup text cell writer: random strings with
// markup, line breaks and grid overruns are pushed through the character
// channel, and every cell write is compared with a cycle-free prediction.
// ----------------------------------------------------------------------------
module tb_markup_text_cell_writer;

   localparam int unsigned RANDOM_CHARS = 1000;
   localparam int unsigned LONG_HOLD    = 200;
   localparam int unsigned DRAIN_CYCLES = 4;

   // -------------------------------------------------------------------------
   // predicts cell writes from accepted requests and checks the results
   // -------------------------------------------------------------------------
   class cell_scoreboard;
      mtcw_pkg::cfg_type      regs;
      logic [7:0]             cur_col;
      logic [7:0]             cur_row;
      bit                     special_on;
      bit                     highlight_on;
      bit                     underline_on;
      bit                     ended;
      mtcw_pkg::rsp_item_type expected_cells[$];
      int unsigned            mismatches;

      function new();
         regs.grid_columns         = mtcw_pkg::GRID_COLUMNS_RESET;
         regs.grid_rows            = mtcw_pkg::GRID_ROWS_RESET;
         regs.normal_text_color    = '0;
         regs.special_text_color   = '0;
         regs.normal_back_color    = '0;
         regs.highlight_back_color = '0;
         cur_col      = '0;
         cur_row      = '0;
         special_on   = 1'b0;
         highlight_on = 1'b0;
         underline_on = 1'b0;
         ended        = 1'b1;
         mismatches   = 0;
      endfunction

      function void set_register(logic [2:0] idx, logic [31:0] value);
         case (idx)
            mtcw_pkg::REG_GRID_COLUMNS:   regs.grid_columns         = value[7:0];
            mtcw_pkg::REG_GRID_ROWS:      regs.grid_rows            = value[7:0];
            mtcw_pkg::REG_NORMAL_TEXT:    regs.normal_text_color    = value[15:0];
            mtcw_pkg::REG_SPECIAL_TEXT:   regs.special_text_color   = value[15:0];
            mtcw_pkg::REG_NORMAL_BACK:    regs.normal_back_color    = value[15:0];
            mtcw_pkg::REG_HIGHLIGHT_BACK: regs.highlight_back_color = value[15:0];
            default: ;
         endcase
      endfunction

      function void note_char(mtcw_pkg::req_item_type req);
         mtcw_pkg::rsp_item_type predicted;
         if (req.string_start) begin
            cur_col      = req.start_column;
            cur_row      = req.start_row;
            special_on   = 1'b0;
            highlight_on = 1'b0;
            underline_on = 1'b0;
            ended        = 1'b0;
         end
         if (ended)
            return;
         if (req.char_code == mtcw_pkg::CHAR_NUL || cur_col >= regs.grid_columns ||
             cur_row >= regs.grid_rows) begin
            ended = 1'b1;
            return;
         end
         case (req.char_code)
            mtcw_pkg::CHAR_CR, mtcw_pkg::CHAR_LF: cur_row = cur_row + 8'd1;
            mtcw_pkg::CHAR_SPECIAL_ON:  special_on = 1'b1;
            mtcw_pkg::CHAR_SPECIAL_OFF: special_on = 1'b0;
            mtcw_pkg::CHAR_HILITE_ON:   highlight_on = 1'b1;
            mtcw_pkg::CHAR_HILITE_OFF:  highlight_on = 1'b0;
            mtcw_pkg::CHAR_UNDERLINE:   underline_on = !underline_on;
            default: begin
               predicted.cell_column = cur_col;
               predicted.cell_row    = cur_row;
               predicted.glyph_code  = {underline_on, req.char_code};
               predicted.fore_color  = special_on ? regs.special_text_color
                                                  : regs.normal_text_color;
               predicted.back_color  = highlight_on ? regs.highlight_back_color
                                                    : regs.normal_back_color;
               expected_cells.push_back(predicted);
               cur_col = cur_col + 8'd1;
            end
         endcase
      endfunction

      function void compare_field(string field_name, int unsigned want,
                                  int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, field_name, want, got);
            mismatches++;
         end
      endfunction

      function void check_cell(mtcw_pkg::rsp_item_type got);
         mtcw_pkg::rsp_item_type want;
         if (expected_cells.size() == 0) begin
            $display("%0t: cell write with nothing expected: expected none, actual %p",
                     $time, got);
            mismatches++;
            return;
         end
         want = expected_cells.pop_front();
         compare_field("cell_column", want.cell_column, got.cell_column);
         compare_field("cell_row",    want.cell_row,    got.cell_row);
         compare_field("glyph_code",  want.glyph_code,  got.glyph_code);
         compare_field("fore_color",  want.fore_color,  got.fore_color);
         compare_field("back_color",  want.back_color,  got.back_color);
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                                csr_psel;
   logic                                csr_penable;
   logic                                csr_pwrite;
   logic [mtcw_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [mtcw_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [mtcw_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                                csr_pready;

   mtcw_req_if req_if ();
   mtcw_rsp_if rsp_if ();

   cell_scoreboard sb = new();

   bit          idle_on   = 1'b1;
   int unsigned long_hold = 0;
   int unsigned chars_sent;

   markup_text_cell_writer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(5_000_000);
      $display("Verification failed");
      $finish;
   end

   // observe both handshakes at the rising edge
   always @(posedge clock) begin : observe
      mtcw_pkg::rsp_item_type rsp_seen;
      mtcw_pkg::req_item_type req_seen;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_seen = {rsp_if.cell_column, rsp_if.cell_row, rsp_if.glyph_code,
                        rsp_if.fore_color, rsp_if.back_color};
            sb.check_cell(rsp_seen);
         end
         if (req_if.valid && req_if.ready) begin
            req_seen = {req_if.char_code, req_if.string_start,
                        req_if.start_column, req_if.start_row};
            sb.note_char(req_seen);
         end
      end
   end

   // cell write sink: random stalls, plus one long hold when asked
   initial begin : cell_sink
      int unsigned gap;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (long_hold) @(negedge clock);
            long_hold = 0;
         end
         gap = idle_on ? $urandom_range(0, 15) : 0;
         if (gap != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         @(negedge clock);
      end
   end

   // all driver tasks start and end on a falling edge
   task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_register(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_grid(input logic [7:0] cols, input logic [7:0] rows,
                             input logic [15:0] normal_fg, input logic [15:0] special_fg,
                             input logic [15:0] normal_bg, input logic [15:0] highlight_bg);
      write_register(mtcw_pkg::REG_GRID_COLUMNS,   {24'd0, cols});
      write_register(mtcw_pkg::REG_GRID_ROWS,      {24'd0, rows});
      write_register(mtcw_pkg::REG_NORMAL_TEXT,    {16'd0, normal_fg});
      write_register(mtcw_pkg::REG_SPECIAL_TEXT,   {16'd0, special_fg});
      write_register(mtcw_pkg::REG_NORMAL_BACK,    {16'd0, normal_bg});
      write_register(mtcw_pkg::REG_HIGHLIGHT_BACK, {16'd0, highlight_bg});
   endtask

   task automatic send_char(input mtcw_pkg::req_item_type item);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 15) : 0;
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.char_code    <= item.char_code;
      req_if.string_start <= item.string_start;
      req_if.start_column <= item.start_column;
      req_if.start_row    <= item.start_row;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      chars_sent++;
   endtask

   task automatic send_code(input logic [6:0] code, input logic start,
                            input logic [7:0] col, input logic [7:0] row);
      mtcw_pkg::req_item_type item;
      item.char_code    = code;
      item.string_start = start;
      item.start_column = col;
      item.start_row    = row;
      send_char(item);
   endtask

   // wait for outstanding cells, then give non-writing characters time to retire
   task automatic wait_for_drain();
      while (sb.expected_cells.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [6:0] random_char();
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 60)
         return 7'($urandom_range(32, 126));
      if (k < 76) begin
         case ($urandom_range(0, 4))
            0:       return mtcw_pkg::CHAR_SPECIAL_ON;
            1:       return mtcw_pkg::CHAR_SPECIAL_OFF;
            2:       return mtcw_pkg::CHAR_HILITE_ON;
            3:       return mtcw_pkg::CHAR_HILITE_OFF;
            default: return mtcw_pkg::CHAR_UNDERLINE;
         endcase
      end
      if (k < 82)
         return $urandom_range(0, 1) ? mtcw_pkg::CHAR_CR : mtcw_pkg::CHAR_LF;
      return 7'($urandom_range(0, 127));
   endfunction

   task automatic send_string(input logic [7:0] cols, input logic [7:0] rows);
      int unsigned pick;
      int unsigned len;
      logic [7:0]  col0;
      logic [7:0]  row0;
      pick = $urandom_range(0, 9);
      if (pick < 7 && cols != 0 && rows != 0) begin
         col0 = 8'($urandom_range(0, cols - 1));
         row0 = 8'($urandom_range(0, rows - 1));
      end else if (pick < 9) begin
         // close to the right or bottom edge, may start just outside
         col0 = cols - 8'($urandom_range(0, 3));
         row0 = rows - 8'($urandom_range(0, 2));
      end else begin
         col0 = 8'($urandom_range(0, 255));
         row0 = 8'($urandom_range(0, 255));
      end
      len = $urandom_range(1, 24);
      for (int unsigned k = 0; k < len; k++) begin
         if (k == 0)
            send_code(random_char(), 1'b1, col0, row0);
         else
            // occasional restart in the middle of a string
            send_code(random_char(), $urandom_range(0, 49) == 0,
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 1))
         send_code(mtcw_pkg::CHAR_NUL, 1'b0, 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3))
            send_code(7'($urandom_range(0, 127)), 1'b0,
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic run_phase(input int unsigned phase);
      logic [7:0]  cols;
      logic [7:0]  rows;
      logic [15:0] fg0, fg1, bg0, bg1;
      int unsigned strings;
      case (phase % 8)
         0: begin cols = 8'd40;  rows = 8'd30;  end
         1: begin cols = 8'd1;   rows = 8'd1;   end
         2: begin cols = 8'd255; rows = 8'd255; end
         3: begin cols = 8'd0;   rows = 8'($urandom_range(1, 255)); end
         5: begin cols = 8'($urandom_range(1, 255)); rows = 8'd0; end
         default: begin
            cols = 8'($urandom_range(1, 64));
            rows = 8'($urandom_range(1, 32));
         end
      endcase
      if (phase % 5 == 0) begin
         fg0 = 16'h0000; fg1 = 16'hFFFF; bg0 = 16'hFFFF; bg1 = 16'h0000;
      end else begin
         fg0 = 16'($urandom); fg1 = 16'($urandom);
         bg0 = 16'($urandom); bg1 = 16'($urandom);
      end
      write_grid(cols, rows, fg0, fg1, bg0, bg1);
      idle_on = (phase % 3 != 2);
      if (phase % 6 == 4) begin
         // sink holds off while the source streams back to back
         idle_on   = 1'b0;
         long_hold = LONG_HOLD;
      end
      strings = (cols == 0 || rows == 0) ? 4 : $urandom_range(5, 10);
      repeat (strings) send_string(cols, rows);
      req_if.valid <= 1'b0;
      wait_for_drain();
   endtask

   initial begin
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.char_code    = '0;
      req_if.string_start = 1'b0;
      req_if.start_column = '0;
      req_if.start_row    = '0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_grid(8'd40, 8'd30, 16'h0000, 16'hFFFF, 16'h5A5A, 16'hA5A5);

      // directed: markup, underline, line breaks, end and overrun cases
      send_code(7'h41, 1'b0, 8'hFF, 8'hFF);            // ignored, no string yet
      send_code(7'h48, 1'b1, 8'd0, 8'd0);
      send_code(mtcw_pkg::CHAR_SPECIAL_ON, 1'b0, 8'd0, 8'd0);
      send_code(7'h78, 1'b0, 8'd0, 8'd0);
      send_code(mtcw_pkg::CHAR_SPECIAL_OFF, 1'b0, 8'd0, 8'd0);
      send_code(mtcw_pkg::CHAR_HILITE_ON, 1'b0, 8'd0, 8'd0);
      send_code(7'h79, 1'b0, 8'd0, 8'd0);
      send_code(mtcw_pkg::CHAR_HILITE_OFF, 1'b0, 8'd0, 8'd0);
      send_code(mtcw_pkg::CHAR_UNDERLINE, 1'b0, 8'd0, 8'd0);
      send_code(7'h7F, 1'b0, 8'd0, 8'd0);
      send_code(mtcw_pkg::CHAR_UNDERLINE, 1'b0, 8'd0, 8'd0);
      send_code(mtcw_pkg::CHAR_CR, 1'b0, 8'd0, 8'd0);
      send_code(7'h61, 1'b0, 8'd0, 8'd0);
      send_code(mtcw_pkg::CHAR_LF, 1'b0, 8'd0, 8'd0);
      send_code(7'h62, 1'b0, 8'd0, 8'd0);
      send_code(mtcw_pkg::CHAR_NUL, 1'b0, 8'd0, 8'd0);
      send_code(7'h63, 1'b0, 8'd0, 8'd0);             // after end of string
      send_code(7'h7A, 1'b1, 8'd39, 8'd29);           // last cell of the grid
      send_code(7'h71, 1'b0, 8'd0, 8'd0);             // runs off the right edge
      send_code(7'h72, 1'b0, 8'd0, 8'd0);
      send_code(7'h01, 1'b1, 8'd255, 8'd255);         // starts outside
      send_code(mtcw_pkg::CHAR_NUL, 1'b1, 8'd5, 8'd5);
      send_code(7'h64, 1'b0, 8'd0, 8'd0);
      send_code(mtcw_pkg::CHAR_SPECIAL_ON, 1'b1, 8'd0, 8'd0);
      send_code(7'h65, 1'b1, 8'd1, 8'd1);             // restart clears markup
      req_if.valid <= 1'b0;
      wait_for_drain();

      chars_sent = 0;
      for (int unsigned phase = 0; chars_sent < RANDOM_CHARS; phase++)
         run_phase(phase);
      wait_for_drain();

      if (sb.expected_cells.size() != 0)
         $display("%0t: %0d cell writes never arrived", $time, sb.expected_cells.size());
      if (sb.mismatches == 0 && sb.expected_cells.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/mtcw_pkg.sv
hw/rtl/mtcw_req_if.sv
hw/rtl/mtcw_rsp_if.sv
hw/rtl/mtcw_csr.sv
hw/rtl/mtcw_engine.sv
hw/rtl/mtcw_rsp_stage.sv
hw/rtl/markup_text_cell_writer.sv
dv/tb_markup_text_cell_writer.sv
